@@ rtl/scba_pkg.sv @@
// scba_pkg: widths, codes and size class tables of the size class block allocator
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

    localparam int unsigned ADDR_W          = 20;
    localparam int unsigned SIZE_W          = 16;
    localparam int unsigned MODE_W          = 2;
    localparam int unsigned STAT_W          = 2;
    localparam int unsigned NEED_W          = SIZE_W + 1;
    localparam int unsigned NUM_CLASSES     = 17;
    localparam int unsigned CLS_W           = $clog2(NUM_CLASSES);
    localparam int unsigned LINK_W          = ADDR_W + 1;
    localparam int unsigned LEFT_W          = 11;
    localparam int unsigned BLK_SZ_W        = 12;
    localparam int unsigned CHUNK_W         = 15;
    localparam int unsigned HDR_BYTES       = 4;
    localparam int unsigned MAX_BLOCK_BYTES = 2076;
    localparam int unsigned POOL_BYTES_DEF  = 1048576;

    localparam logic [BLK_SZ_W-1:0] BLK_SIZE [NUM_CLASSES] = '{
        12'd12, 12'd16, 12'd28, 12'd36, 12'd60, 12'd76, 12'd88, 12'd116, 12'd148,
        12'd196, 12'd260, 12'd292, 12'd436, 12'd676, 12'd868, 12'd1068, 12'd2076
    };

    localparam logic [CHUNK_W-1:0] CHUNK_SIZE [NUM_CLASSES] = '{
        CHUNK_W'(12 * 1024), CHUNK_W'(16 * 1024), CHUNK_W'(28 * 585),
        CHUNK_W'(36 * 455), CHUNK_W'(60 * 273), CHUNK_W'(76 * 215),
        CHUNK_W'(88 * 186), CHUNK_W'(116 * 141), CHUNK_W'(148 * 110),
        CHUNK_W'(196 * 83), CHUNK_W'(260 * 63), CHUNK_W'(292 * 56),
        CHUNK_W'(436 * 37), CHUNK_W'(676 * 24), CHUNK_W'(868 * 18),
        CHUNK_W'(1068 * 15), CHUNK_W'(2076 * 7)
    };

    // blocks per chunk minus the one handed out when the chunk is cut
    localparam logic [LEFT_W-1:0] BLOCKS_LEFT [NUM_CLASSES] = '{
        11'd1023, 11'd1023, 11'd584, 11'd454, 11'd272, 11'd214, 11'd185, 11'd140,
        11'd109, 11'd82, 11'd62, 11'd55, 11'd36, 11'd23, 11'd17, 11'd14, 11'd6
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_BIG  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DONE,
        S_ALLOC_WB,
        S_FREE_WB
    } state_t;

endpackage

`default_nettype wire

@@ rtl/scba_req_if.sv @@
// scba_req_if: request channel of the allocator, valid/ready plus request payload
// depends on scba_pkg
`timescale 1ns / 1ps
`default_nettype none

interface scba_req_if;
    import scba_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output mode, output size_bytes, output address,
                    input ready);
    modport sink   (input valid, input mode, input size_bytes, input address,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/scba_res_if.sv @@
// scba_res_if: result channel of the allocator, valid/ready plus result payload
// depends on scba_pkg
`timescale 1ns / 1ps
`default_nettype none

interface scba_res_if;
    import scba_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address_res;
    logic [STAT_W-1:0] status;

    modport source (output valid, output address_res, output status, input ready);
    modport sink   (input valid, input address_res, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/size_class_block_allocator_top.sv @@
// size_class_block_allocator_top: segregated free list allocator over a byte pool
// depends on scba_pkg, scba_req_if, scba_res_if
//
//   channel  dir  payload                          transfer when
//   req      in   mode, size_bytes, address        req.valid & req.ready
//   res      out  address_res, status              res.valid & res.ready
//
// every request has an accept cycle, which issues any read of the header/link
// memory, and a finish cycle, which uses the registered read data and writes
// the result register. reset clears class heads, carve state, pool top and the
// handshake; the header/link memory is not cleared. the result register holds
// while res is stalled, and the next request is taken meanwhile; the finish
// cycle waits until the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module size_class_block_allocator_top #(
    parameter int unsigned POOL_BYTES = scba_pkg::POOL_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    scba_req_if.sink    req,
    scba_res_if.source  res
);
    import scba_pkg::*;

    localparam int unsigned DEPTH = POOL_BYTES / 4;
    localparam int unsigned WI_W  = $clog2(DEPTH);
    localparam int unsigned PA_W  = $clog2(POOL_BYTES);
    localparam int unsigned PT_W  = PA_W + 1;
    localparam int unsigned BW    = (PA_W > ADDR_W) ? PA_W : ADDR_W;
    localparam int unsigned CMP_W = ((ADDR_W > PT_W) ? ADDR_W : PT_W) + 1;

    state_t              state_reg, state_next;

    logic [LINK_W-1:0]   class_head_reg [NUM_CLASSES];
    logic [ADDR_W-1:0]   carve_next_reg [NUM_CLASSES];
    logic [LEFT_W-1:0]   carve_left_reg [NUM_CLASSES];
    logic [PT_W-1:0]     pool_top_reg, pool_top_next;

    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [WI_W-1:0]     word_reg, word_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    status_t             pend_stat_reg, pend_stat_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    status_t             out_stat_reg, out_stat_next;

    logic [LINK_W-1:0]   link_mem [DEPTH];
    logic [LINK_W-1:0]   mem_rdata_reg;
    logic                mem_we, mem_re;
    logic [WI_W-1:0]     mem_waddr, mem_raddr;
    logic [LINK_W-1:0]   mem_wdata;

    logic                head_we;
    logic [CLS_W-1:0]    head_widx;
    logic [LINK_W-1:0]   head_wdata;
    logic                carve_we;
    logic [ADDR_W-1:0]   carve_next_wdata;
    logic [LEFT_W-1:0]   carve_left_wdata;
    logic                clear_all;

    logic                req_fire, res_free;
    mode_t               req_mode;
    logic [NEED_W-1:0]   need;
    logic                size_zero, size_big;
    logic [CLS_W-1:0]    cls_sel;
    logic [CLS_W-1:0]    tag;
    logic                tag_ok;
    logic [CLS_W-1:0]    head_ridx;
    logic [LINK_W-1:0]   head_rd;
    logic                pool_fit;
    logic [ADDR_W-3:0]   free_w;
    logic                free_ok;
    logic                alloc_from_list;
    logic [BW-1:0]       blk;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign res_free  = !out_valid_reg || res.ready;
    assign req_mode  = mode_t'(req.mode);

    assign res.valid       = out_valid_reg;
    assign res.address_res = out_addr_reg;
    assign res.status      = out_stat_reg;

    // class select: smallest block that holds request plus header
    assign need      = NEED_W'(req.size_bytes) + NEED_W'(HDR_BYTES);
    assign size_zero = (req.size_bytes == '0);
    assign size_big  = (need > NEED_W'(MAX_BLOCK_BYTES));

    always_comb
    begin
        cls_sel = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (NEED_W'(BLK_SIZE[i]) >= need)
            begin
                cls_sel = CLS_W'(i);
            end
        end
    end

    assign tag       = mem_rdata_reg[CLS_W-1:0];
    assign tag_ok    = (mem_rdata_reg < LINK_W'(NUM_CLASSES));
    assign head_ridx = (state_reg == S_FREE_WB) ? tag : cls_sel;
    assign head_rd   = class_head_reg[head_ridx];

    assign pool_fit = ((PT_W + 1)'(pool_top_reg) + (PT_W + 1)'(CHUNK_SIZE[cls_sel]))
                      <= (PT_W + 1)'(POOL_BYTES);

    assign free_w  = req.address[ADDR_W-1:2] - (ADDR_W - 2)'(1);
    assign free_ok = (req_mode == MODE_FREE) && (req.address[ADDR_W-1:2] != '0)
                     && ((CMP_W'(free_w) + CMP_W'(3)) <= CMP_W'(pool_top_reg[PT_W-1:2]))
                     && ((CMP_W'(free_w) + CMP_W'(1)) < CMP_W'(DEPTH));

    assign alloc_from_list = (req_mode == MODE_ALLOC) && !size_zero && !size_big
                             && head_rd[ADDR_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (alloc_from_list)
                    begin
                        state_next = S_ALLOC_WB;
                    end
                    else if (free_ok)
                    begin
                        state_next = S_FREE_WB;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE, S_ALLOC_WB, S_FREE_WB:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        blk              = '0;
        cls_next         = cls_reg;
        word_next        = word_reg;
        pend_addr_next   = pend_addr_reg;
        pend_stat_next   = pend_stat_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_addr_next    = out_addr_reg;
        out_stat_next    = out_stat_reg;
        pool_top_next    = pool_top_reg;
        head_we          = 1'b0;
        head_widx        = cls_reg;
        head_wdata       = mem_rdata_reg;
        carve_we         = 1'b0;
        carve_next_wdata = '0;
        carve_left_wdata = '0;
        clear_all        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    pend_addr_next = '0;
                    pend_stat_next = ST_OK;
                    cls_next       = cls_sel;
                    case (req_mode)
                        MODE_ALLOC:
                        begin
                            if (size_zero)
                            begin
                                pend_stat_next = ST_ZERO;
                            end
                            else if (size_big)
                            begin
                                pend_stat_next = ST_BIG;
                            end
                            else if (head_rd[ADDR_W])
                            begin
                                blk            = BW'(head_rd[ADDR_W-1:0]);
                                mem_re         = 1'b1;
                                mem_raddr      = blk[WI_W+1:2] + WI_W'(1);
                                mem_we         = 1'b1;
                                mem_waddr      = blk[WI_W+1:2];
                                mem_wdata      = LINK_W'(cls_sel);
                                pend_addr_next = ADDR_W'(blk + BW'(HDR_BYTES));
                            end
                            else if (carve_left_reg[cls_sel] != '0)
                            begin
                                blk              = BW'(carve_next_reg[cls_sel]);
                                carve_we         = 1'b1;
                                carve_next_wdata = ADDR_W'(blk + BW'(BLK_SIZE[cls_sel]));
                                carve_left_wdata = carve_left_reg[cls_sel] - LEFT_W'(1);
                                mem_we           = 1'b1;
                                mem_waddr        = blk[WI_W+1:2];
                                mem_wdata        = LINK_W'(cls_sel);
                                pend_addr_next   = ADDR_W'(blk + BW'(HDR_BYTES));
                            end
                            else if (!pool_fit)
                            begin
                                pend_stat_next = ST_FULL;
                            end
                            else
                            begin
                                blk              = BW'(pool_top_reg[PA_W-1:0]);
                                carve_we         = 1'b1;
                                carve_next_wdata = ADDR_W'(blk + BW'(BLK_SIZE[cls_sel]));
                                carve_left_wdata = BLOCKS_LEFT[cls_sel];
                                pool_top_next    = pool_top_reg + PT_W'(CHUNK_SIZE[cls_sel]);
                                mem_we           = 1'b1;
                                mem_waddr        = blk[WI_W+1:2];
                                mem_wdata        = LINK_W'(cls_sel);
                                pend_addr_next   = ADDR_W'(blk + BW'(HDR_BYTES));
                            end
                        end
                        MODE_FREE:
                        begin
                            if (free_ok)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = WI_W'(free_w);
                                word_next = WI_W'(free_w);
                            end
                        end
                        MODE_CLEAR:
                        begin
                            clear_all     = 1'b1;
                            pool_top_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ALLOC_WB:
            begin
                if (res_free)
                begin
                    head_we        = 1'b1;
                    head_widx      = cls_reg;
                    head_wdata     = mem_rdata_reg;
                    out_valid_next = 1'b1;
                    out_addr_next  = pend_addr_reg;
                    out_stat_next  = pend_stat_reg;
                end
            end
            S_FREE_WB:
            begin
                if (res_free)
                begin
                    if (tag_ok)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = word_reg + WI_W'(1);
                        mem_wdata  = head_rd;
                        head_we    = 1'b1;
                        head_widx  = tag;
                        head_wdata = {1'b1, ADDR_W'({word_reg, 2'b00})};
                    end
                    out_valid_next = 1'b1;
                    out_addr_next  = pend_addr_reg;
                    out_stat_next  = pend_stat_reg;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = pend_addr_reg;
                    out_stat_next  = pend_stat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pool_top_reg  <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                class_head_reg[i] <= '0;
                carve_next_reg[i] <= '0;
                carve_left_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pool_top_reg  <= pool_top_next;
            if (clear_all)
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    class_head_reg[i] <= '0;
                    carve_next_reg[i] <= '0;
                    carve_left_reg[i] <= '0;
                end
            end
            else
            begin
                if (head_we)
                begin
                    class_head_reg[head_widx] <= head_wdata;
                end
                if (carve_we)
                begin
                    carve_next_reg[cls_sel] <= carve_next_wdata;
                    carve_left_reg[cls_sel] <= carve_left_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg       <= cls_next;
        word_reg      <= word_next;
        pend_addr_reg <= pend_addr_next;
        pend_stat_reg <= pend_stat_next;
        out_addr_reg  <= out_addr_next;
        out_stat_reg  <= out_stat_next;
    end

    // header/link memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= link_mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_mem_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("header and link access hit the same word");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (PT_W + 1)'(pool_top_reg) <= (PT_W + 1)'(POOL_BYTES))
        else $error("pool top beyond pool");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("request transfer did not start work");

    a_res_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result raised without a finish cycle");

    a_free_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE_WB && !res_free) |=>
            ($stable(word_reg) && $stable(mem_rdata_reg) && state_reg == S_FREE_WB))
        else $error("stalled free lost its block");
`endif

endmodule

`default_nettype wire
